>>> design/wse_pkg.sv
// Package for the word span enumerator: fixed field widths, character codes
// and limits shared by the design. No dependencies.
package wse_pkg;

  localparam int unsigned OUT_POS_BITS     = 16;
  localparam int unsigned LIMIT_BITS       = 5;
  localparam logic [4:0]  SPAN_LIMIT_RESET = 5'd3;

  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // C-locale isspace.
  function automatic logic is_space(input logic [7:0] ch);
    is_space = ((ch >= CHAR_TAB) && (ch <= CHAR_CR)) || (ch == CHAR_SPACE);
  endfunction

endpackage

>>> design/word_span_enumerator.sv
// Word span enumerator top level: word tracking window, span sequencer and
// output register. Depends on wse_pkg.
//
// Flow: a byte that starts no word and ends no text is taken in S_IDLE and leaves it
// there. A word start goes to S_OLD, which retires each stale or overflow start by
// walking it in S_EMIT (one span per cycle, held while the output stalls) before the
// word is appended; an end of text passes S_CLOSE and S_FIN, which drain every pending
// start the same way. Bytes are taken only in S_IDLE, so each waits for the last one.
// Reset (rst, synchronous) empties the window, clears position and word state, and sets
// span_limit to 3.
module word_span_enumerator #(
  parameter int unsigned WINDOW_WORDS = 8,
  parameter int unsigned POS_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // final_byte
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] span_begin, [31:16] span_finish
  output logic        m_tlast,   // last_span
  // Configuration: span_limit.
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  localparam int unsigned OW = $clog2(WINDOW_WORDS);      // slot index width
  localparam int unsigned CW = $clog2(WINDOW_WORDS + 1);  // count width
  localparam int unsigned SW = CW + 1;                    // slot sum width
  localparam int unsigned RB = wse_pkg::RES_CNT_BITS;
  localparam logic [POS_BITS-1:0] POS_LIMIT = {POS_BITS{1'b1}};

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a byte
  localparam logic [2:0] S_OLD   = 3'd1;  // retire stale or overflow starts, then append
  localparam logic [2:0] S_EMIT  = 3'd2;  // walk the window for one start
  localparam logic [2:0] S_CLOSE = 3'd3;  // end of text: close an open word
  localparam logic [2:0] S_FIN   = 3'd4;  // end of text: drain the window

  logic [2:0]          state;
  logic [POS_BITS-1:0] pos;          // offset of the next byte
  logic                in_word;      // currently within a word
  logic [CW-1:0]       pending;      // starts held in the window
  logic [OW-1:0]       oldest;       // slot of the oldest start
  logic [CW-1:0]       k;            // walk offset from the oldest slot
  logic [POS_BITS-1:0] sbase;        // start of the span list being emitted
  logic [POS_BITS-1:0] wpos;         // start of the word being appended
  logic                fin_step;     // the current byte ends the text
  logic                drain;        // the walk belongs to the end-of-text drain
  logic [RB-1:0]       cnt;          // results written for the current byte
  logic [wse_pkg::LIMIT_BITS-1:0] span_limit;

  // Window of word starts and ends, one entry per pending word. Entries are
  // read only after they were written, so they need no reset.
  logic [POS_BITS-1:0] start_ring [WINDOW_WORDS];
  logic [POS_BITS-1:0] end_ring   [WINDOW_WORDS];

  // Slot arithmetic modulo the window size.
  logic [SW-1:0] sum_last, sum_app, sum_walk, sum_next;
  logic [OW-1:0] slot_last, slot_app, slot_walk, slot_next;

  assign sum_last  = SW'(oldest) + SW'(pending) - SW'(1);
  assign sum_app   = SW'(oldest) + SW'(pending);
  assign sum_walk  = SW'(oldest) + SW'(k);
  assign sum_next  = SW'(oldest) + SW'(1);
  assign slot_last = OW'((sum_last >= SW'(WINDOW_WORDS)) ? sum_last - SW'(WINDOW_WORDS) : sum_last);
  assign slot_app  = OW'((sum_app  >= SW'(WINDOW_WORDS)) ? sum_app  - SW'(WINDOW_WORDS) : sum_app);
  assign slot_walk = OW'((sum_walk >= SW'(WINDOW_WORDS)) ? sum_walk - SW'(WINDOW_WORDS) : sum_walk);
  assign slot_next = OW'((sum_next >= SW'(WINDOW_WORDS)) ? sum_next - SW'(WINDOW_WORDS) : sum_next);

  // One read address into the window serves every state.
  logic [OW-1:0]       rd_slot;
  logic [POS_BITS-1:0] start_rd, end_rd;

  assign rd_slot  = (state == S_EMIT) ? slot_walk : oldest;
  assign start_rd = start_ring[rd_slot];
  assign end_rd   = end_ring[rd_slot];

  // The shared difference and compare unit. While retiring stale starts it
  // measures the new word against the oldest start; while walking it measures
  // a window entry against the start whose list is being emitted.
  logic [POS_BITS-1:0] op_a, op_b, diff;
  logic                far;

  assign op_a = (state == S_OLD) ? wpos : start_rd;
  assign op_b = (state == S_OLD) ? start_rd : sbase;
  assign diff = op_a - op_b;
  assign far  = diff >= POS_BITS'(span_limit);

  // Byte classification at the accepting edge.
  logic accept, in_range, is_ws, word_open, word_close;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign in_range   = (pos != POS_LIMIT);
  assign is_ws      = wse_pkg::is_space(s_tdata);
  assign word_open  = in_range && !is_ws && !in_word;
  assign word_close = in_range && is_ws && in_word;

  // Walk control: the walk continues while entries remain inside the limit.
  logic walk_more, out_free, can_put, put_span;

  assign walk_more = (k < pending) && !far;
  assign out_free  = !m_tvalid || m_tready;
  assign can_put   = cnt < RB'(wse_pkg::MAX_RESULTS);
  assign put_span  = (state == S_EMIT) && walk_more && out_free && can_put;

  // Oldest start is due for retirement before the new word goes in.
  logic retire_old;
  assign retire_old = ((pending != '0) && far) || (pending == CW'(WINDOW_WORDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      span_limit <= wse_pkg::SPAN_LIMIT_RESET;
    end else if (cfg_we) begin
      span_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      in_word  <= 1'b0;
      pending  <= '0;
      oldest   <= '0;
      k        <= '0;
      fin_step <= 1'b0;
      drain    <= 1'b0;
      cnt      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            fin_step <= s_tlast;
            cnt      <= '0;
            wpos     <= pos;
            if (in_range) begin
              pos <= pos + POS_BITS'(1);
            end
            if (word_close) begin
              end_ring[slot_last] <= pos;
              in_word             <= 1'b0;
            end
            if (word_open) begin
              state <= S_OLD;
            end else if (s_tlast) begin
              state <= S_CLOSE;
            end
          end
        end
        S_OLD: begin
          if (retire_old) begin
            sbase <= start_rd;
            k     <= '0;
            drain <= 1'b0;
            state <= S_EMIT;
          end else begin
            // Append the new word; its end follows when it closes.
            start_ring[slot_app] <= wpos;
            end_ring[slot_app]   <= wpos;
            pending              <= pending + CW'(1);
            in_word              <= 1'b1;
            state                <= fin_step ? S_CLOSE : S_IDLE;
          end
        end
        S_EMIT: begin
          if (walk_more) begin
            // A span beyond the per-byte result cap is dropped, not stalled.
            if (out_free || !can_put) begin
              k <= k + CW'(1);
              if (can_put) begin
                cnt <= cnt + RB'(1);
              end
            end
          end else begin
            oldest  <= slot_next;
            pending <= pending - CW'(1);
            state   <= drain ? S_FIN : S_OLD;
          end
        end
        S_CLOSE: begin
          if (in_word && (pending != '0)) begin
            end_ring[slot_last] <= pos;
          end
          in_word <= 1'b0;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (pending != '0) begin
            sbase <= start_rd;
            k     <= '0;
            drain <= 1'b1;
            state <= S_EMIT;
          end else begin
            // Text done: the next text starts at offset zero.
            pos     <= '0;
            oldest  <= '0;
            in_word <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register. The final span of a text is either the single span of
  // the last start in the drain, or the one that fills the result cap.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (put_span) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_span) begin
      m_tdata <= {wse_pkg::OUT_POS_BITS'(end_rd), wse_pkg::OUT_POS_BITS'(sbase)};
      m_tlast <= fin_step && ((cnt == RB'(wse_pkg::MAX_RESULTS - 1)) ||
                              (drain && (pending == CW'(1))));
    end
  end

  // The window never holds more starts than it has slots.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CW'(WINDOW_WORDS))
    else $error("window holds more starts than slots");

  // A finished drain leaves the next text at offset zero with an empty window.
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && (pending == '0) |=> (pos == '0) && (pending == '0) && !in_word)
    else $error("text end did not clear position and window");

  // Nothing is ever emitted past the per-byte result cap.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= RB'(wse_pkg::MAX_RESULTS))
    else $error("result count passed the cap");

  // A span goes out only while walking a non-empty window.
  a_put_ctx: assert property (@(posedge clk) disable iff (rst)
    put_span |-> (pending != '0) && (k < pending))
    else $error("span emitted outside a window walk");

endmodule
